// ===== rtl/core/tracker_pattern_row_parser_macros.svh =====
// Assertion macros shared by the pattern row parser RTL.
`ifndef TRACKER_PATTERN_ROW_PARSER_MACROS_SVH
`define TRACKER_PATTERN_ROW_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define TPRP_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tprp assertion failed");
// Implication from an antecedent to a consequent in the next cycle.
`define TPRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tprp assertion failed");
`else
`define TPRP_ASSERT(lbl, cond)
`define TPRP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/tprp_pkg.sv =====
// Types, constants and effect conversion for the pattern row parser.
package tprp_pkg;

  // Channels at or above this number end their entry after the channel byte.
  localparam int unsigned CHANNEL_LIMIT = 64;

  // Parser phase codes.
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ROWS_HI = 4'd1;
  localparam logic [3:0] PH_RSZ_LO  = 4'd2;
  localparam logic [3:0] PH_RSZ_HI  = 4'd3;
  localparam logic [3:0] PH_FLAGS   = 4'd4;
  localparam logic [3:0] PH_CHAN    = 4'd5;
  localparam logic [3:0] PH_NOTE    = 4'd6;
  localparam logic [3:0] PH_INST    = 4'd7;
  localparam logic [3:0] PH_VOL     = 4'd8;
  localparam logic [3:0] PH_FX0     = 4'd9;
  localparam logic [3:0] PH_FX1     = 4'd10;
  localparam logic [3:0] PH_EXTRA   = 4'd11;

  // Entry flag bits.
  localparam int unsigned FLAG_NOTE = 7;
  localparam int unsigned FLAG_INST = 6;
  localparam int unsigned FLAG_VOL  = 5;
  localparam int unsigned FLAG_FX   = 4;

  // Output effect codes.
  localparam logic [4:0] EFF_NONE      = 5'd0;
  localparam logic [4:0] EFF_VOLSLIDE  = 5'd1;
  localparam logic [4:0] EFF_PORTAUP   = 5'd2;
  localparam logic [4:0] EFF_PORTADOWN = 5'd3;
  localparam logic [4:0] EFF_TONEPORTA = 5'd4;
  localparam logic [4:0] EFF_TPVOL     = 5'd5;
  localparam logic [4:0] EFF_SPECIAL   = 5'd6;
  localparam logic [4:0] EFF_VIBRATO   = 5'd7;
  localparam logic [4:0] EFF_VIBVOL    = 5'd8;
  localparam logic [4:0] EFF_TREMOLO   = 5'd9;
  localparam logic [4:0] EFF_OFFSET    = 5'd10;
  localparam logic [4:0] EFF_RETRIG    = 5'd11;
  localparam logic [4:0] EFF_POSJUMP   = 5'd12;
  localparam logic [4:0] EFF_BREAK     = 5'd13;
  localparam logic [4:0] EFF_SPEED     = 5'd14;
  localparam logic [4:0] EFF_TEMPO     = 5'd15;
  localparam logic [4:0] EFF_ARPEGGIO  = 5'd16;

  // Raw effect bytes of the file format.
  localparam logic [7:0] SRC_VSL_UP      = 8'h01;
  localparam logic [7:0] SRC_VSL_FINEUP  = 8'h02;
  localparam logic [7:0] SRC_VSL_DOWN    = 8'h03;
  localparam logic [7:0] SRC_VSL_FINEDN  = 8'h04;
  localparam logic [7:0] SRC_PUP_FINE    = 8'h0B;
  localparam logic [7:0] SRC_PUP         = 8'h0C;
  localparam logic [7:0] SRC_PDN_FINE    = 8'h0D;
  localparam logic [7:0] SRC_PDN         = 8'h0E;
  localparam logic [7:0] SRC_TPORTA      = 8'h0F;
  localparam logic [7:0] SRC_TPVOL_UP    = 8'h10;
  localparam logic [7:0] SRC_GLISSANDO   = 8'h11;
  localparam logic [7:0] SRC_TPVOL_DN    = 8'h12;
  localparam logic [7:0] SRC_GLISS_SET   = 8'h13;
  localparam logic [7:0] SRC_VIBRATO     = 8'h15;
  localparam logic [7:0] SRC_VIB_WAVE    = 8'h16;
  localparam logic [7:0] SRC_VIBVOL_UP   = 8'h17;
  localparam logic [7:0] SRC_VIBVOL_DN   = 8'h18;
  localparam logic [7:0] SRC_TREMOLO     = 8'h1F;
  localparam logic [7:0] SRC_TREM_WAVE   = 8'h20;
  localparam logic [7:0] SRC_OFFSET      = 8'h29;
  localparam logic [7:0] SRC_RETRIG      = 8'h2A;
  localparam logic [7:0] SRC_NOTE_CUT    = 8'h2B;
  localparam logic [7:0] SRC_NOTE_DELAY  = 8'h2C;
  localparam logic [7:0] SRC_POSJUMP     = 8'h33;
  localparam logic [7:0] SRC_BREAK       = 8'h34;
  localparam logic [7:0] SRC_LOOP_SET    = 8'h35;
  localparam logic [7:0] SRC_PAT_DELAY   = 8'h36;
  localparam logic [7:0] SRC_SPEED       = 8'h3D;
  localparam logic [7:0] SRC_TEMPO       = 8'h3E;
  localparam logic [7:0] SRC_ARPEGGIO    = 8'h47;
  localparam logic [7:0] SRC_FINETUNE    = 8'h48;
  localparam logic [7:0] SRC_PANNING     = 8'h49;

  // Result tdata, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]  pad;
    logic [7:0]  effect_param;
    logic [4:0]  effect_code;
    logic [6:0]  volume_level;
    logic        has_volume;
    logic [8:0]  instrument_number;
    logic        has_instrument;
    logic [7:0]  note_value;
    logic        has_note;
    logic [5:0]  channel_number;
    logic [15:0] row_number;
  } result_data_t;

  // Converted effect.
  typedef struct packed {
    logic [4:0] code;
    logic [7:0] param;
  } effect_t;

  // Next field after a given field, or done when none is left.
  typedef struct packed {
    logic       done;
    logic [3:0] phase;
  } step_t;

  // Portamento parameter conversion.
  function automatic logic [7:0] conv_porta(input logic [7:0] p, input logic nl);
    logic [7:0] r;
    if (nl) begin
      r = p;
    end else if (p < 8'd4) begin
      r = p | 8'hF0;
    end else begin
      r = p >> 2;
    end
    return r;
  endfunction

  // Renumbers an effect and converts its parameter.
  function automatic effect_t fx_decode(input logic [7:0] e0, input logic [7:0] e1,
                                        input logic nl);
    effect_t    f;
    logic [7:0] lo;
    lo = e1 & 8'h0F;
    f.code = EFF_NONE;
    f.param = e1;
    case (e0)
      SRC_VSL_UP: begin
        f.code = EFF_VOLSLIDE;
        f.param = (nl ? (e1 << 4) : ((e1 & 8'h1E) << 3)) | 8'h0F;
      end
      SRC_VSL_FINEUP: begin
        f.code = EFF_VOLSLIDE;
        f.param = (nl ? (e1 << 4) : (e1 << 3)) & 8'h0F;
      end
      SRC_VSL_DOWN: begin
        f.code = EFF_VOLSLIDE;
        f.param = (nl ? e1 : (e1 >> 1)) | 8'hF0;
      end
      SRC_VSL_FINEDN: begin
        f.code = EFF_VOLSLIDE;
        if (nl) begin
          f.param = lo;
        end else if (e1 < 8'd2) begin
          f.param = e1 | 8'hF0;
        end else begin
          f.param = (e1 >> 1) & 8'h0F;
        end
      end
      SRC_PUP_FINE: begin
        f.code = EFF_PORTAUP;
        f.param = 8'hF0 | conv_porta(e1, nl);
      end
      SRC_PUP: begin
        f.code = EFF_PORTAUP;
        f.param = conv_porta(e1, nl);
      end
      SRC_PDN_FINE: begin
        f.code = EFF_PORTADOWN;
        f.param = 8'hF0 | conv_porta(e1, nl);
      end
      SRC_PDN: begin
        f.code = EFF_PORTADOWN;
        f.param = conv_porta(e1, nl);
      end
      SRC_TPORTA: begin
        f.code = EFF_TONEPORTA;
        f.param = nl ? e1 : (e1 >> 2);
      end
      SRC_TPVOL_UP: begin
        f.code = EFF_TPVOL;
        f.param = e1 & 8'hF0;
      end
      SRC_TPVOL_DN: begin
        f.code = EFF_TPVOL;
        f.param = (e1 >> 4) & 8'h0F;
      end
      SRC_GLISSANDO: begin
        f.code = EFF_SPECIAL;
        f.param = 8'h10 | (e1 & 8'h01);
      end
      SRC_GLISS_SET: begin
        f.code = EFF_SPECIAL;
      end
      SRC_VIBRATO: begin
        f.code = EFF_VIBRATO;
      end
      SRC_VIB_WAVE: begin
        f.code = EFF_SPECIAL;
        f.param = 8'h30 | lo;
      end
      SRC_VIBVOL_UP: begin
        f.code = EFF_VIBVOL;
        f.param = e1 & 8'hF0;
      end
      SRC_VIBVOL_DN: begin
        f.code = EFF_VIBVOL;
      end
      SRC_TREMOLO: begin
        f.code = EFF_TREMOLO;
      end
      SRC_TREM_WAVE: begin
        f.code = EFF_SPECIAL;
        f.param = 8'h40 | lo;
      end
      SRC_OFFSET: begin
        f.code = EFF_OFFSET;
      end
      SRC_RETRIG: begin
        f.code = EFF_RETRIG;
      end
      SRC_NOTE_CUT: begin
        f.code = EFF_SPECIAL;
        f.param = 8'hC0 | e1;
      end
      SRC_NOTE_DELAY: begin
        f.code = EFF_SPECIAL;
        f.param = 8'hD0 | e1;
      end
      SRC_POSJUMP: begin
        f.code = EFF_POSJUMP;
        f.param = e1 >> 1;
      end
      SRC_BREAK: begin
        f.code = EFF_BREAK;
        f.param = 8'h00;
      end
      SRC_LOOP_SET: begin
        f.code = EFF_SPECIAL;
        f.param = 8'hB0 | lo;
      end
      SRC_PAT_DELAY: begin
        f.code = EFF_SPECIAL;
        f.param = 8'hE0 | lo;
      end
      SRC_SPEED: begin
        f.code = EFF_SPEED;
      end
      SRC_TEMPO: begin
        f.code = EFF_TEMPO;
      end
      SRC_ARPEGGIO: begin
        f.code = EFF_ARPEGGIO;
      end
      SRC_FINETUNE: begin
        f.code = EFF_SPECIAL;
        f.param = 8'h20 | lo;
      end
      SRC_PANNING: begin
        f.code = EFF_SPECIAL;
        f.param = 8'h80 | lo;
      end
      default: begin
        f.code = EFF_NONE;
        f.param = e1;
      end
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/core/tracker_pattern_row_parser.sv =====
// Pattern body parser: decodes a byte stream into one result per pattern entry.
//
//   channel  dir  payload                              handshake
//   s_*      in   tdata: data_byte; tuser: pattern_start tvalid/tready
//   m_*      out  tdata: entry fields; tuser: entry_valid; tlast: pattern_end
//   cfg_*    in   wdata: new_layout_mode                cfg_wen, no wait
//
// One byte is taken per clock unless a held result stalls it; the parser state
// and result register update in the same cycle; a byte's result shows next cycle.
// s_tready is low only while a held result is not taken (m_tvalid && !m_tready).
// Synchronous reset returns the parser to waiting for a row count and empties
// the result register; no clearing pass is needed.
`include "tracker_pattern_row_parser_macros.svh"

module tracker_pattern_row_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] pattern_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [15:0] row_number, [21:16] channel_number,
                                 // [22] has_note, [30:23] note_value,
                                 // [31] has_instrument, [40:32] instrument_number,
                                 // [41] has_volume, [48:42] volume_level,
                                 // [53:49] effect_code, [61:54] effect_param,
                                 // [63:62] zero
  output logic        m_tuser,   // [0] entry_valid
  output logic        m_tlast,   // pattern_end
  input  logic        cfg_wen,
  input  logic        cfg_wdata  // new_layout_mode
);

  // Parser state.
  logic        new_layout_mode;
  logic [3:0]  phase, phase_next;
  logic [15:0] rows_total, rows_total_next;
  logic [15:0] current_row, current_row_next;
  logic [15:0] row_length, row_length_next;
  logic [15:0] row_bytes_used, row_bytes_used_next;
  logic [7:0]  entry_flags, entry_flags_next;
  logic [5:0]  entry_channel, entry_channel_next;
  logic [7:0]  effect_byte, effect_byte_next;
  logic [1:0]  extra_count, extra_count_next;
  logic [7:0]  note, note_next;
  logic [8:0]  inst, inst_next;
  logic [6:0]  vol, vol_next;
  logic [7:0]  param, param_next;

  logic        acc;
  logic        fin;
  logic        fin_valid;
  logic        emit;
  logic        out_end;
  logic        zero_rows;
  logic [15:0] used_bump;
  logic [15:0] row_inc;
  logic [7:0]  d;
  logic [6:0]  vol_clip;
  logic [7:0]  note_old;
  logic [3:0]  hi;
  tprp_pkg::step_t      nxt;
  tprp_pkg::effect_t    fx;
  tprp_pkg::result_data_t res;

  // Next present field after the given stage (0 channel, 1 note, 2 instr, 3 vol).
  function automatic tprp_pkg::step_t next_field(input logic [7:0] flags,
                                                 input logic [1:0] stage);
    tprp_pkg::step_t s;
    s.done = 1'b0;
    s.phase = tprp_pkg::PH_FLAGS;
    if (stage < 2'd1 && flags[tprp_pkg::FLAG_NOTE]) begin
      s.phase = tprp_pkg::PH_NOTE;
    end else if (stage < 2'd2 && flags[tprp_pkg::FLAG_INST]) begin
      s.phase = tprp_pkg::PH_INST;
    end else if (stage < 2'd3 && flags[tprp_pkg::FLAG_VOL]) begin
      s.phase = tprp_pkg::PH_VOL;
    end else if (flags[tprp_pkg::FLAG_FX]) begin
      s.phase = tprp_pkg::PH_FX0;
    end else begin
      s.done = 1'b1;
    end
    return s;
  endfunction

  assign d = s_tdata;
  assign s_tready = !m_tvalid || m_tready;
  assign acc = s_tvalid && s_tready;
  assign used_bump = (row_bytes_used != 16'hFFFF) ? row_bytes_used + 16'd1 : row_bytes_used;
  assign row_inc = current_row + 16'd1;
  assign vol_clip = d[7] ? 7'd127 : d[6:0];
  assign hi = d[7:4];
  assign note_old = {4'd0, d[3:0]} + {1'b0, hi, 3'd0} + {2'd0, hi, 2'd0} + 8'd13;

  // One byte of the parser: next state and whether an entry finishes here.
  always_comb begin
    phase_next = phase;
    rows_total_next = rows_total;
    current_row_next = current_row;
    row_length_next = row_length;
    row_bytes_used_next = row_bytes_used;
    entry_flags_next = entry_flags;
    entry_channel_next = entry_channel;
    effect_byte_next = effect_byte;
    extra_count_next = extra_count;
    note_next = note;
    inst_next = inst;
    vol_next = vol;
    param_next = param;
    fin = 1'b0;
    fin_valid = 1'b0;
    zero_rows = 1'b0;
    out_end = 1'b0;
    nxt = next_field(entry_flags, 2'd0);
    if (s_tuser) begin
      rows_total_next = {8'd0, d};
      current_row_next = 16'd0;
      phase_next = tprp_pkg::PH_ROWS_HI;
    end else begin
      case (phase)
        tprp_pkg::PH_ROWS_HI: begin
          rows_total_next = {d, rows_total[7:0]};
          current_row_next = 16'd0;
          if (rows_total_next == 16'd0) begin
            phase_next = tprp_pkg::PH_IDLE;
            zero_rows = 1'b1;
          end else begin
            phase_next = tprp_pkg::PH_RSZ_LO;
          end
        end
        tprp_pkg::PH_RSZ_LO: begin
          row_length_next = {8'd0, d};
          phase_next = tprp_pkg::PH_RSZ_HI;
        end
        tprp_pkg::PH_RSZ_HI: begin
          row_length_next = {d, row_length[7:0]};
          row_bytes_used_next = 16'd0;
          fin = 1'b1;
        end
        tprp_pkg::PH_FLAGS: begin
          row_bytes_used_next = used_bump;
          entry_flags_next = d;
          phase_next = tprp_pkg::PH_CHAN;
        end
        tprp_pkg::PH_CHAN: begin
          row_bytes_used_next = used_bump;
          if ({1'b0, d} >= 9'(tprp_pkg::CHANNEL_LIMIT)) begin
            fin = 1'b1;
          end else begin
            entry_channel_next = d[5:0];
            nxt = next_field(entry_flags, 2'd0);
            phase_next = nxt.phase;
            fin = nxt.done;
            fin_valid = nxt.done;
          end
        end
        tprp_pkg::PH_NOTE: begin
          row_bytes_used_next = used_bump;
          if (new_layout_mode) begin
            note_next = (d < 8'd85) ? d + 8'd36 : d;
          end else if (d == 8'hFF) begin
            note_next = 8'd254;
          end else if (d < 8'd129) begin
            note_next = note_old;
          end else begin
            note_next = 8'd0;
          end
          nxt = next_field(entry_flags, 2'd1);
          phase_next = nxt.phase;
          fin = nxt.done;
          fin_valid = nxt.done;
        end
        tprp_pkg::PH_INST: begin
          row_bytes_used_next = used_bump;
          inst_next = {1'b0, d} + 9'd1;
          nxt = next_field(entry_flags, 2'd2);
          phase_next = nxt.phase;
          fin = nxt.done;
          fin_valid = nxt.done;
        end
        tprp_pkg::PH_VOL: begin
          row_bytes_used_next = used_bump;
          vol_next = 7'(({1'b0, vol_clip} + 8'd1) >> 1);
          nxt = next_field(entry_flags, 2'd3);
          phase_next = nxt.phase;
          fin = nxt.done;
          fin_valid = nxt.done;
        end
        tprp_pkg::PH_FX0: begin
          row_bytes_used_next = used_bump;
          effect_byte_next = d;
          phase_next = tprp_pkg::PH_FX1;
        end
        tprp_pkg::PH_FX1: begin
          row_bytes_used_next = used_bump;
          param_next = d;
          if (effect_byte == tprp_pkg::SRC_OFFSET) begin
            extra_count_next = 2'd2;
            phase_next = tprp_pkg::PH_EXTRA;
          end else if (effect_byte == tprp_pkg::SRC_POSJUMP) begin
            extra_count_next = 2'd1;
            phase_next = tprp_pkg::PH_EXTRA;
          end else begin
            fin = 1'b1;
            fin_valid = 1'b1;
          end
        end
        tprp_pkg::PH_EXTRA: begin
          row_bytes_used_next = used_bump;
          if (effect_byte == tprp_pkg::SRC_OFFSET && extra_count == 2'd2) begin
            param_next = d;
          end
          extra_count_next = extra_count - 2'd1;
          if (extra_count_next == 2'd0) begin
            fin = 1'b1;
            fin_valid = 1'b1;
          end
        end
        default: begin
          phase_next = tprp_pkg::PH_IDLE;
        end
      endcase
    end
    // End of an entry or an empty row: continue the row or finish it.
    if (fin) begin
      if ({1'b0, row_bytes_used_next} + 17'd3 < {1'b0, row_length_next}) begin
        phase_next = tprp_pkg::PH_FLAGS;
      end else begin
        current_row_next = row_inc;
        if (row_inc >= rows_total) begin
          phase_next = tprp_pkg::PH_IDLE;
          out_end = 1'b1;
        end else begin
          phase_next = tprp_pkg::PH_RSZ_LO;
        end
      end
    end
    if (zero_rows) begin
      out_end = 1'b1;
    end
  end

  assign emit = fin_valid || out_end;

  // Result fields; everything but row and end is zero for a result without entry.
  always_comb begin
    fx = tprp_pkg::fx_decode(effect_byte_next, param_next, new_layout_mode);
    res = '0;
    res.row_number = current_row;
    if (fin_valid) begin
      res.channel_number = entry_channel_next;
      if (entry_flags[tprp_pkg::FLAG_NOTE]) begin
        res.has_note = 1'b1;
        res.note_value = note_next;
      end
      if (entry_flags[tprp_pkg::FLAG_INST]) begin
        res.has_instrument = 1'b1;
        res.instrument_number = inst_next;
      end
      if (entry_flags[tprp_pkg::FLAG_VOL]) begin
        res.has_volume = 1'b1;
        res.volume_level = vol_next;
      end
      if (entry_flags[tprp_pkg::FLAG_FX]) begin
        res.effect_code = fx.code;
        res.effect_param = fx.param;
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      new_layout_mode <= 1'b0;
    end else if (cfg_wen) begin
      new_layout_mode <= cfg_wdata;
    end
  end

  // Parser state update on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tprp_pkg::PH_IDLE;
      rows_total <= 16'd0;
      current_row <= 16'd0;
      row_length <= 16'd0;
      row_bytes_used <= 16'd0;
      entry_flags <= 8'd0;
      entry_channel <= 6'd0;
      effect_byte <= 8'd0;
      extra_count <= 2'd0;
    end else if (acc) begin
      phase <= phase_next;
      rows_total <= rows_total_next;
      current_row <= current_row_next;
      row_length <= row_length_next;
      row_bytes_used <= row_bytes_used_next;
      entry_flags <= entry_flags_next;
      entry_channel <= entry_channel_next;
      effect_byte <= effect_byte_next;
      extra_count <= extra_count_next;
    end
  end

  // Field values collected during an entry.
  always_ff @(posedge clk) begin
    if (acc) begin
      note <= note_next;
      inst <= inst_next;
      vol <= vol_next;
      param <= param_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (acc && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      m_tdata <= res;
      m_tuser <= fin_valid;
      m_tlast <= out_end;
    end
  end

  // A result without an entry only ever reports the end of a pattern.
  `TPRP_ASSERT(a_noentry_is_end, !(m_tvalid && !m_tuser) || m_tlast)
  // A result that ends the pattern leaves the parser waiting for a new start.
  `TPRP_ASSERT_NEXT(a_end_goes_idle, !rst && acc && out_end, phase == tprp_pkg::PH_IDLE)
  // The parser moves only on accepted items.
  `TPRP_ASSERT_NEXT(a_phase_holds, !rst && !acc, $stable(phase) && $stable(current_row))
  // A held result stalls the input side.
  `TPRP_ASSERT(a_stall_blocks_input, !(m_tvalid && !m_tready) || !s_tready)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the pattern row parser: byte stream in, decoded entries out.
module testbench;

  // One decoded result as it leaves the block: tuser, tlast, then tdata.
  typedef struct packed {
    logic                   entry_valid;
    logic                   pattern_end;
    tprp_pkg::result_data_t fields;
  } parsed_entry_t;

  // Receiver stall patterns.
  typedef enum int {READY_ALWAYS, READY_PERIODIC, READY_RANDOM} ready_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_wen = 1'b0;
  logic        cfg_wdata = 1'b0;

  // Pending body bytes as {pattern_start, data_byte}.
  logic [8:0]    pending_bytes[$];
  parsed_entry_t expected_entries[$];
  int            bytes_queued = 0;
  int            bytes_accepted = 0;
  int            failures = 0;
  bit            byte_taken = 1'b0;
  int            gap_left = 0;
  int            burst_left = 0;
  ready_mode_t   ready_mode = READY_ALWAYS;
  int            ready_left = 0;
  int            ready_period = 2;
  int            cycle_count = 0;

  // Predictor copy of the parser state and the layout register.
  logic        layout_mode = 1'b0;
  logic [3:0]  parse_phase = tprp_pkg::PH_IDLE;
  logic [15:0] rows_in_pattern = '0;
  logic [15:0] row_index = '0;
  logic [15:0] row_span = '0;
  logic [15:0] row_used = '0;
  logic [7:0]  entry_flag_bits = '0;
  logic [5:0]  entry_chan = '0;
  logic [7:0]  fx_raw = '0;
  logic [7:0]  fx_arg = '0;
  logic [1:0]  extra_left = '0;
  logic [7:0]  note_q = '0;
  logic [8:0]  inst_q = '0;
  logic [6:0]  vol_q = '0;

  logic [7:0] known_effects [0:31] = '{
    tprp_pkg::SRC_VSL_UP, tprp_pkg::SRC_VSL_FINEUP, tprp_pkg::SRC_VSL_DOWN,
    tprp_pkg::SRC_VSL_FINEDN, tprp_pkg::SRC_PUP_FINE, tprp_pkg::SRC_PUP,
    tprp_pkg::SRC_PDN_FINE, tprp_pkg::SRC_PDN, tprp_pkg::SRC_TPORTA,
    tprp_pkg::SRC_TPVOL_UP, tprp_pkg::SRC_GLISSANDO, tprp_pkg::SRC_TPVOL_DN,
    tprp_pkg::SRC_GLISS_SET, tprp_pkg::SRC_VIBRATO, tprp_pkg::SRC_VIB_WAVE,
    tprp_pkg::SRC_VIBVOL_UP, tprp_pkg::SRC_VIBVOL_DN, tprp_pkg::SRC_TREMOLO,
    tprp_pkg::SRC_TREM_WAVE, tprp_pkg::SRC_OFFSET, tprp_pkg::SRC_RETRIG,
    tprp_pkg::SRC_NOTE_CUT, tprp_pkg::SRC_NOTE_DELAY, tprp_pkg::SRC_POSJUMP,
    tprp_pkg::SRC_BREAK, tprp_pkg::SRC_LOOP_SET, tprp_pkg::SRC_PAT_DELAY,
    tprp_pkg::SRC_SPEED, tprp_pkg::SRC_TEMPO, tprp_pkg::SRC_ARPEGGIO,
    tprp_pkg::SRC_FINETUNE, tprp_pkg::SRC_PANNING
  };

  // Opening bytes, {pattern_start, data_byte}: junk before any start, an empty
  // pattern, junk after its end, a huge row count with a short row, a dropped
  // channel and a full offset entry, then a row cut off inside an entry.
  logic [8:0] directed_bytes [0:24] = '{
    9'h0A5,
    9'h100, 9'h000,
    9'h05A,
    9'h102, 9'h0FF,
    9'h003, 9'h000,
    9'h00D, 9'h000,
    9'h0F0, 9'h040,
    9'h0F0, 9'h03F, 9'h0FF, 9'h0FF, 9'h0FF, 9'h029, 9'h012, 9'h034, 9'h056,
    9'h0FF, 9'h0FF,
    9'h080, 9'h000
  };

  tracker_pattern_row_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Portamento argument: scaled down in the older layout, small values become fine slides.
  function automatic int porta_arg(input int a, input logic nl);
    if (nl) return a;
    return (a < 4) ? (a | 'hF0) : (a >> 2);
  endfunction

  // Renumbers a raw effect byte; returns {code, parameter}.
  function automatic logic [12:0] remap_effect(input logic [7:0] raw, input logic [7:0] arg,
                                               input logic nl);
    logic [4:0] c;
    int a;
    int p;
    a = arg;
    c = tprp_pkg::EFF_NONE;
    p = a;
    case (raw)
      tprp_pkg::SRC_VSL_UP: begin
        c = tprp_pkg::EFF_VOLSLIDE;
        p = (nl ? (a << 4) : ((a & 'h1E) << 3)) | 'h0F;
      end
      tprp_pkg::SRC_VSL_FINEUP: begin
        c = tprp_pkg::EFF_VOLSLIDE;
        p = (nl ? (a << 4) : (a << 3)) & 'h0F;
      end
      tprp_pkg::SRC_VSL_DOWN: begin
        c = tprp_pkg::EFF_VOLSLIDE;
        p = (nl ? a : (a >> 1)) | 'hF0;
      end
      tprp_pkg::SRC_VSL_FINEDN: begin
        c = tprp_pkg::EFF_VOLSLIDE;
        p = nl ? (a & 'h0F) : ((a < 2) ? (a | 'hF0) : ((a >> 1) & 'h0F));
      end
      tprp_pkg::SRC_PUP_FINE: begin
        c = tprp_pkg::EFF_PORTAUP;
        p = 'hF0 | porta_arg(a, nl);
      end
      tprp_pkg::SRC_PUP: begin
        c = tprp_pkg::EFF_PORTAUP;
        p = porta_arg(a, nl);
      end
      tprp_pkg::SRC_PDN_FINE: begin
        c = tprp_pkg::EFF_PORTADOWN;
        p = 'hF0 | porta_arg(a, nl);
      end
      tprp_pkg::SRC_PDN: begin
        c = tprp_pkg::EFF_PORTADOWN;
        p = porta_arg(a, nl);
      end
      tprp_pkg::SRC_TPORTA: begin
        c = tprp_pkg::EFF_TONEPORTA;
        p = nl ? a : (a >> 2);
      end
      tprp_pkg::SRC_TPVOL_UP: begin
        c = tprp_pkg::EFF_TPVOL;
        p = a & 'hF0;
      end
      tprp_pkg::SRC_TPVOL_DN: begin
        c = tprp_pkg::EFF_TPVOL;
        p = (a >> 4) & 'h0F;
      end
      tprp_pkg::SRC_GLISSANDO: begin
        c = tprp_pkg::EFF_SPECIAL;
        p = 'h10 | (a & 'h01);
      end
      tprp_pkg::SRC_GLISS_SET: c = tprp_pkg::EFF_SPECIAL;
      tprp_pkg::SRC_VIBRATO: c = tprp_pkg::EFF_VIBRATO;
      tprp_pkg::SRC_VIB_WAVE: begin
        c = tprp_pkg::EFF_SPECIAL;
        p = 'h30 | (a & 'h0F);
      end
      tprp_pkg::SRC_VIBVOL_UP: begin
        c = tprp_pkg::EFF_VIBVOL;
        p = a & 'hF0;
      end
      tprp_pkg::SRC_VIBVOL_DN: c = tprp_pkg::EFF_VIBVOL;
      tprp_pkg::SRC_TREMOLO: c = tprp_pkg::EFF_TREMOLO;
      tprp_pkg::SRC_TREM_WAVE: begin
        c = tprp_pkg::EFF_SPECIAL;
        p = 'h40 | (a & 'h0F);
      end
      tprp_pkg::SRC_OFFSET: c = tprp_pkg::EFF_OFFSET;
      tprp_pkg::SRC_RETRIG: c = tprp_pkg::EFF_RETRIG;
      tprp_pkg::SRC_NOTE_CUT: begin
        c = tprp_pkg::EFF_SPECIAL;
        p = 'hC0 | a;
      end
      tprp_pkg::SRC_NOTE_DELAY: begin
        c = tprp_pkg::EFF_SPECIAL;
        p = 'hD0 | a;
      end
      tprp_pkg::SRC_POSJUMP: begin
        c = tprp_pkg::EFF_POSJUMP;
        p = a >> 1;
      end
      tprp_pkg::SRC_BREAK: begin
        c = tprp_pkg::EFF_BREAK;
        p = 0;
      end
      tprp_pkg::SRC_LOOP_SET: begin
        c = tprp_pkg::EFF_SPECIAL;
        p = 'hB0 | (a & 'h0F);
      end
      tprp_pkg::SRC_PAT_DELAY: begin
        c = tprp_pkg::EFF_SPECIAL;
        p = 'hE0 | (a & 'h0F);
      end
      tprp_pkg::SRC_SPEED: c = tprp_pkg::EFF_SPEED;
      tprp_pkg::SRC_TEMPO: c = tprp_pkg::EFF_TEMPO;
      tprp_pkg::SRC_ARPEGGIO: c = tprp_pkg::EFF_ARPEGGIO;
      tprp_pkg::SRC_FINETUNE: begin
        c = tprp_pkg::EFF_SPECIAL;
        p = 'h20 | (a & 'h0F);
      end
      tprp_pkg::SRC_PANNING: begin
        c = tprp_pkg::EFF_SPECIAL;
        p = 'h80 | (a & 'h0F);
      end
      default: begin
        c = tprp_pkg::EFF_NONE;
        p = a;
      end
    endcase
    return {c, p[7:0]};
  endfunction

  function automatic void count_row_byte();
    if (row_used != 16'hFFFF) row_used = row_used + 16'd1;
  endfunction

  // Closes an entry (or an empty row); returns 1 when a result is due.
  function automatic bit finish_entry(input bit valid, output parsed_entry_t r);
    logic [15:0] row;
    bit          ended;
    row = row_index;
    ended = 1'b0;
    r = '0;
    if ({1'b0, row_used} + 17'd3 < {1'b0, row_span}) begin
      parse_phase = tprp_pkg::PH_FLAGS;
    end else begin
      row_index = row_index + 16'd1;
      if (row_index >= rows_in_pattern) begin
        parse_phase = tprp_pkg::PH_IDLE;
        ended = 1'b1;
      end else begin
        parse_phase = tprp_pkg::PH_RSZ_LO;
      end
    end
    if (!valid && !ended) return 1'b0;
    r.entry_valid = valid;
    r.pattern_end = ended;
    r.fields.row_number = row;
    if (valid) begin
      r.fields.channel_number = entry_chan;
      if (entry_flag_bits[tprp_pkg::FLAG_NOTE]) begin
        r.fields.has_note = 1'b1;
        r.fields.note_value = note_q;
      end
      if (entry_flag_bits[tprp_pkg::FLAG_INST]) begin
        r.fields.has_instrument = 1'b1;
        r.fields.instrument_number = inst_q;
      end
      if (entry_flag_bits[tprp_pkg::FLAG_VOL]) begin
        r.fields.has_volume = 1'b1;
        r.fields.volume_level = vol_q;
      end
      if (entry_flag_bits[tprp_pkg::FLAG_FX]) begin
        {r.fields.effect_code, r.fields.effect_param} =
          remap_effect(fx_raw, fx_arg, layout_mode);
      end
    end
    return 1'b1;
  endfunction

  // Moves on to the next present field after stage (0 channel, 1 note, 2 instrument, 3 volume).
  function automatic bit next_field(input int stage, output parsed_entry_t r);
    r = '0;
    if (stage < 1 && entry_flag_bits[tprp_pkg::FLAG_NOTE]) begin
      parse_phase = tprp_pkg::PH_NOTE;
      return 1'b0;
    end
    if (stage < 2 && entry_flag_bits[tprp_pkg::FLAG_INST]) begin
      parse_phase = tprp_pkg::PH_INST;
      return 1'b0;
    end
    if (stage < 3 && entry_flag_bits[tprp_pkg::FLAG_VOL]) begin
      parse_phase = tprp_pkg::PH_VOL;
      return 1'b0;
    end
    if (stage < 4 && entry_flag_bits[tprp_pkg::FLAG_FX]) begin
      parse_phase = tprp_pkg::PH_FX0;
      return 1'b0;
    end
    return finish_entry(1'b1, r);
  endfunction

  // Advances the predicted parser by one body byte; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] d, input logic start,
                                    output parsed_entry_t r);
    int di;
    int n;
    int v;
    di = d;
    r = '0;
    if (start) begin
      rows_in_pattern = {8'h00, d};
      row_index = '0;
      parse_phase = tprp_pkg::PH_ROWS_HI;
      return 1'b0;
    end
    case (parse_phase)
      tprp_pkg::PH_ROWS_HI: begin
        rows_in_pattern[15:8] = d;
        row_index = '0;
        if (rows_in_pattern == 16'd0) begin
          parse_phase = tprp_pkg::PH_IDLE;
          r.pattern_end = 1'b1;
          return 1'b1;
        end
        parse_phase = tprp_pkg::PH_RSZ_LO;
      end
      tprp_pkg::PH_RSZ_LO: begin
        row_span = {8'h00, d};
        parse_phase = tprp_pkg::PH_RSZ_HI;
      end
      tprp_pkg::PH_RSZ_HI: begin
        row_span[15:8] = d;
        row_used = '0;
        if (row_span > 16'd3) parse_phase = tprp_pkg::PH_FLAGS;
        else return finish_entry(1'b0, r);
      end
      tprp_pkg::PH_FLAGS: begin
        count_row_byte();
        entry_flag_bits = d;
        parse_phase = tprp_pkg::PH_CHAN;
      end
      tprp_pkg::PH_CHAN: begin
        count_row_byte();
        if (d >= tprp_pkg::CHANNEL_LIMIT) return finish_entry(1'b0, r);
        entry_chan = d[5:0];
        note_q = '0;
        inst_q = '0;
        vol_q = '0;
        fx_arg = '0;
        fx_raw = '0;
        extra_left = '0;
        return next_field(0, r);
      end
      tprp_pkg::PH_NOTE: begin
        count_row_byte();
        if (layout_mode) n = (di < 85) ? di + 36 : di;
        else if (di == 'hFF) n = 254;
        else if (di < 129) n = (di & 'h0F) + 12 * (di >> 4) + 13;
        else n = 0;
        note_q = n[7:0];
        return next_field(1, r);
      end
      tprp_pkg::PH_INST: begin
        count_row_byte();
        inst_q = {1'b0, d} + 9'd1;
        return next_field(2, r);
      end
      tprp_pkg::PH_VOL: begin
        count_row_byte();
        v = (di > 127) ? 127 : di;
        v = (v + 1) / 2;
        vol_q = v[6:0];
        return next_field(3, r);
      end
      tprp_pkg::PH_FX0: begin
        count_row_byte();
        fx_raw = d;
        parse_phase = tprp_pkg::PH_FX1;
      end
      tprp_pkg::PH_FX1: begin
        count_row_byte();
        fx_arg = d;
        if (fx_raw == tprp_pkg::SRC_OFFSET) begin
          extra_left = 2'd2;
          parse_phase = tprp_pkg::PH_EXTRA;
        end else if (fx_raw == tprp_pkg::SRC_POSJUMP) begin
          extra_left = 2'd1;
          parse_phase = tprp_pkg::PH_EXTRA;
        end else begin
          return finish_entry(1'b1, r);
        end
      end
      tprp_pkg::PH_EXTRA: begin
        count_row_byte();
        // The offset takes its parameter from the first extra byte.
        if (fx_raw == tprp_pkg::SRC_OFFSET && extra_left == 2'd2) fx_arg = d;
        extra_left = extra_left - 2'd1;
        if (extra_left == 2'd0) return finish_entry(1'b1, r);
      end
      default: parse_phase = tprp_pkg::PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  function automatic string entry_text(input parsed_entry_t e);
    return {$sformatf("valid=%0d end=%0d row=%0d ch=%0d ", e.entry_valid, e.pattern_end,
                      e.fields.row_number, e.fields.channel_number),
            $sformatf("note=%0d/%0d inst=%0d/%0d ", e.fields.has_note, e.fields.note_value,
                      e.fields.has_instrument, e.fields.instrument_number),
            $sformatf("vol=%0d/%0d fx=%0d/%02h pad=%0d", e.fields.has_volume,
                      e.fields.volume_level, e.fields.effect_code, e.fields.effect_param,
                      e.fields.pad)};
  endfunction

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic queue_byte(input logic [8:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  // Waits until every byte is taken and every result checked, then lets the pipe settle.
  task automatic wait_drained();
    do @(negedge clk); while (bytes_accepted != bytes_queued || expected_entries.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Queues one pattern with random rows and entries, sometimes cut off early.
  task automatic queue_pattern(output int n);
    logic [8:0] pat[$];
    logic [7:0] row_body[$];
    logic [7:0] fl;
    logic [7:0] ch;
    logic [7:0] fx;
    int         rows;
    int         size;
    int         keep;
    rows = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 5);
    pat.push_back({1'b1, 8'(rows)});
    pat.push_back({1'b0, 8'(rows >> 8)});
    repeat (rows) begin
      row_body.delete();
      repeat ($urandom_range(0, 4)) begin
        fl = 8'($urandom);
        ch = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(64, 255))
                                         : 8'($urandom_range(0, 63));
        row_body.push_back(fl);
        row_body.push_back(ch);
        if (ch < tprp_pkg::CHANNEL_LIMIT) begin
          if (fl[tprp_pkg::FLAG_NOTE]) begin
            case ($urandom_range(0, 3))
              0: row_body.push_back(8'hFF);
              1: row_body.push_back(8'($urandom_range(0, 128)));
              2: row_body.push_back(8'($urandom_range(80, 135)));
              default: row_body.push_back(8'($urandom));
            endcase
          end
          if (fl[tprp_pkg::FLAG_INST]) row_body.push_back(8'($urandom));
          if (fl[tprp_pkg::FLAG_VOL]) row_body.push_back(8'($urandom));
          if (fl[tprp_pkg::FLAG_FX]) begin
            fx = ($urandom_range(0, 6) == 0) ? 8'($urandom)
                                             : known_effects[$urandom_range(0, 31)];
            row_body.push_back(fx);
            row_body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 4))
                                                           : 8'($urandom));
            if (fx == tprp_pkg::SRC_OFFSET) begin
              row_body.push_back(8'($urandom));
              row_body.push_back(8'($urandom));
            end else if (fx == tprp_pkg::SRC_POSJUMP) begin
              row_body.push_back(8'($urandom));
            end
          end
        end
      end
      // The row size normally counts its own two bytes; sometimes it is off either way.
      size = row_body.size() + 2;
      if ($urandom_range(0, 7) == 0) size = $urandom_range(0, row_body.size() + 6);
      pat.push_back({1'b0, 8'(size)});
      pat.push_back({1'b0, 8'(size >> 8)});
      foreach (row_body[i]) pat.push_back({1'b0, row_body[i]});
    end
    keep = pat.size();
    if ($urandom_range(0, 9) == 0) keep = $urandom_range(1, pat.size());
    for (int i = 0; i < keep; i++) queue_byte(pat[i]);
    n = keep;
  endtask

  // Sender: bursts of items with random gaps; an offered item is held until taken.
  always @(negedge clk) begin : drive_bytes
    logic [8:0] item;
    logic       show;
    show = s_tvalid && !byte_taken;
    byte_taken = 1'b0;
    if (!show && !rst) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_bytes.size() > 0) begin
        item = pending_bytes.pop_front();
        s_tdata <= item[7:0];
        s_tuser <= item[8];
        show = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 16);
          gap_left = $urandom_range(1, 8);
        end
      end
    end
    s_tvalid <= show;
  end

  // Receiver: switches between always ready, a periodic stall and random stalls.
  always @(negedge clk) begin : drive_ready
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 2));
      ready_left = $urandom_range(30, 300);
      ready_period = $urandom_range(2, 7);
    end
    ready_left--;
    cycle_count++;
    case (ready_mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_PERIODIC: m_tready <= (cycle_count % ready_period) != 0;
      default: m_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  // Predicts on every accepted byte and checks every accepted result.
  always @(posedge clk) begin : check_results
    parsed_entry_t predicted;
    parsed_entry_t got;
    parsed_entry_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        byte_taken = 1'b1;
        bytes_accepted++;
        if (parse_byte(s_tdata, s_tuser, predicted)) expected_entries.push_back(predicted);
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tlast, m_tdata};
        if (expected_entries.size() == 0) begin
          log_failure({"unexpected result: ", entry_text(got)});
        end else begin
          want = expected_entries.pop_front();
          if (got !== want) begin
            log_failure({"mismatch\n  expected ", entry_text(want),
                         "\n  actual   ", entry_text(got)});
          end
        end
      end
    end
  end

  // Stimulus: directed bytes in the reset layout, then random phases across both layouts.
  initial begin : run_stimulus
    int  phase_items;
    int  n;
    logic mode;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_bytes[i]) queue_byte(directed_bytes[i]);
    for (int ph_i = 0; ph_i < 6; ph_i++) begin
      wait_drained();
      mode = (ph_i < 4) ? ((ph_i % 2) == 0) : 1'($urandom_range(0, 1));
      cfg_wen <= 1'b1;
      cfg_wdata <= mode;
      layout_mode = mode;
      @(negedge clk);
      cfg_wen <= 1'b0;
      @(posedge clk);
      phase_items = 0;
      while (phase_items < 240) begin
        case ($urandom_range(0, 9))
          0: begin
            // Raw noise with an occasional restart.
            repeat ($urandom_range(1, 8)) begin
              queue_byte({1'($urandom_range(0, 7) == 0), 8'($urandom)});
            end
          end
          1: begin
            // Stray bytes after a pattern.
            queue_pattern(n);
            phase_items += n;
            repeat ($urandom_range(1, 4)) queue_byte({1'b0, 8'($urandom)});
          end
          default: begin
            queue_pattern(n);
            phase_items += n;
          end
        endcase
      end
    end
    wait_drained();
    repeat (8) @(negedge clk);
    if (failures == 0 && expected_entries.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
